// File: hw/rtl/strobed_symbol_frame_receiver_macros.svh
// ---------------------------------------------------------------------------
// Strobed symbol frame receiver assertion macros
// Clocked assertion helpers. They are empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef STROBED_SYMBOL_FRAME_RECEIVER_MACROS_SVH
`define STROBED_SYMBOL_FRAME_RECEIVER_MACROS_SVH
`ifndef SYNTH
// Checked only while out of reset
`define SSFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked during reset as well
`define SSFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSFR_ASSERT(lbl, prop, msg)
`define SSFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/ssfr_pkg.sv
// ---------------------------------------------------------------------------
// Strobed symbol frame receiver package
// Phase and event codes, field widths and the result record.
// ---------------------------------------------------------------------------
package ssfr_pkg;

  localparam int SYM_W         = 6;
  localparam int IN_DATA_W     = 8;
  localparam int LEN_W         = 32;
  localparam int BYTE_W        = 8;
  localparam int NIB_W         = 4;
  localparam int DIGIT_W       = 3;
  localparam int EV_W          = 3;
  localparam int OUT_DATA_W    = 96;
  localparam int LENGTH_DIGITS_DEF = 8;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 32'd65536;

  localparam logic [SYM_W-1:0] SYNC_HI   = 6'd63;
  localparam logic [SYM_W-1:0] SYNC_ZERO = 6'd0;
  localparam logic [SYM_W-1:0] SYNC_END  = 6'd2;
  localparam logic [SYM_W-1:0] HEX_MAX   = 6'd15;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_GOT1 = 4'd1,
    PH_GOT2 = 4'd2,
    PH_GOT3 = 4'd3,
    PH_LEN  = 4'd4,
    PH_DHI  = 4'd5,
    PH_DLO  = 4'd6,
    PH_CHI  = 4'd7,
    PH_CLO  = 4'd8
  } phase_t;

  typedef enum logic [EV_W-1:0] {
    EV_HEADER  = 3'd0,
    EV_DATA    = 3'd1,
    EV_END     = 3'd2,
    EV_BADLEN  = 3'd3,
    EV_OVER    = 3'd4,
    EV_BADDATA = 3'd5
  } event_t;

  typedef struct packed {
    event_t              event_res;
    logic [LEN_W-1:0]    length;
    logic [BYTE_W-1:0]   data_byte;
    logic [LEN_W-1:0]    byte_index;
    logic [BYTE_W-1:0]   computed_xor;
    logic [BYTE_W-1:0]   received_xor;
    logic                sum_match;
    logic                last;
  } res_t;

endpackage

// File: hw/rtl/strobed_symbol_frame_receiver.sv
// ---------------------------------------------------------------------------
// Strobed symbol frame receiver
// Hunts the preamble 63,0,63,2, gathers a hex length, assembles payload bytes
// and checks the trailing XOR checksum.
// ---------------------------------------------------------------------------
// One symbol request is taken every cycle unless the input register stalls.
// A symbol is held in an input register, decoded against the frame state
// combinationally and any result lands in the output register, which drives
// out_tvalid. A symbol that yields a result waits in the input register only
// while the output register holds an untaken result. Write max_length while
// no frame traffic is in flight; it applies to the next length header.
`include "strobed_symbol_frame_receiver_macros.svh"

module strobed_symbol_frame_receiver #(
  parameter int LENGTH_DIGITS = ssfr_pkg::LENGTH_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [5:0] symbol, [7:6] zero
  input  logic [ssfr_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] length, [39:32] data_byte, [71:40] byte_index,
  // [79:72] computed_xor, [87:80] received_xor, [88] sum_match, [95:89] zero
  output logic [ssfr_pkg::OUT_DATA_W-1:0] out_tdata,
  // [2:0] event_res
  output logic [ssfr_pkg::EV_W-1:0]       out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssfr_pkg::LEN_W-1:0]      cfg_data
);
  import ssfr_pkg::*;

  localparam logic [3:0] DIGITS = 4'(LENGTH_DIGITS);

  logic [LEN_W-1:0]   max_length_r;

  logic               in_vld_r;
  logic [SYM_W-1:0]   sym_r;

  phase_t             phase_r, phase_nxt;
  logic [DIGIT_W-1:0] digit_count_r, digit_count_nxt;
  logic [LEN_W-1:0]   length_accum_r, length_accum_nxt;
  logic [LEN_W-1:0]   frame_length_r, frame_length_nxt;
  logic [LEN_W-1:0]   bytes_done_r, bytes_done_nxt;
  logic [NIB_W-1:0]   high_nibble_r, high_nibble_nxt;
  logic [BYTE_W-1:0]  running_xor_r, running_xor_nxt;

  logic               out_vld_r;
  res_t               out_r;
  res_t               res;
  logic               has_res;
  logic               adv;

  logic               hex_ok;
  logic [NIB_W-1:0]   nib;
  logic [LEN_W-1:0]   len_v;
  logic               len_final;
  logic [BYTE_W-1:0]  byte_v;
  logic [BYTE_W-1:0]  xor_v;
  logic [LEN_W-1:0]   bytes_inc;

  assign hex_ok    = (sym_r <= HEX_MAX);
  assign nib       = sym_r[NIB_W-1:0];
  assign len_v     = {length_accum_r[LEN_W-NIB_W-1:0], nib};
  assign len_final = !((4'(digit_count_r) + 4'd1) < DIGITS);
  assign byte_v    = {high_nibble_r, nib};
  assign xor_v     = running_xor_r ^ byte_v;
  assign bytes_inc = bytes_done_r + 32'd1;

  assign adv       = in_vld_r && (!has_res || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    digit_count_nxt  = digit_count_r;
    length_accum_nxt = length_accum_r;
    frame_length_nxt = frame_length_r;
    bytes_done_nxt   = bytes_done_r;
    high_nibble_nxt  = high_nibble_r;
    running_xor_nxt  = running_xor_r;
    unique case (phase_r)
      PH_GOT1: begin
        if (sym_r == SYNC_ZERO) begin
          phase_nxt = PH_GOT2;
        end else begin
          phase_nxt = (sym_r == SYNC_HI) ? PH_GOT1 : PH_HUNT;
        end
      end
      PH_GOT2: phase_nxt = (sym_r == SYNC_HI) ? PH_GOT3 : PH_HUNT;
      PH_GOT3: begin
        if (sym_r == SYNC_END) begin
          phase_nxt        = PH_LEN;
          digit_count_nxt  = '0;
          length_accum_nxt = '0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (!hex_ok) begin
          phase_nxt        = PH_HUNT;
          digit_count_nxt  = '0;
          length_accum_nxt = '0;
        end else if (!len_final) begin
          length_accum_nxt = len_v;
          digit_count_nxt  = digit_count_r + 3'd1;
        end else if (len_v > max_length_r) begin
          phase_nxt        = PH_HUNT;
          digit_count_nxt  = '0;
          length_accum_nxt = '0;
        end else begin
          frame_length_nxt = len_v;
          bytes_done_nxt   = '0;
          running_xor_nxt  = '0;
          high_nibble_nxt  = '0;
          digit_count_nxt  = '0;
          length_accum_nxt = '0;
          phase_nxt        = (len_v == '0) ? PH_CHI : PH_DHI;
        end
      end
      PH_DHI, PH_CHI, PH_DLO, PH_CLO: begin
        if (!hex_ok) begin
          phase_nxt        = PH_HUNT;
          digit_count_nxt  = '0;
          length_accum_nxt = '0;
        end else if (phase_r == PH_DHI || phase_r == PH_CHI) begin
          high_nibble_nxt = nib;
          phase_nxt       = (phase_r == PH_DHI) ? PH_DLO : PH_CLO;
        end else if (phase_r == PH_DLO) begin
          running_xor_nxt = xor_v;
          bytes_done_nxt  = bytes_inc;
          phase_nxt       = (bytes_inc >= frame_length_r) ? PH_CHI : PH_DHI;
        end else begin
          phase_nxt        = PH_HUNT;
          digit_count_nxt  = '0;
          length_accum_nxt = '0;
        end
      end
      default: phase_nxt = (sym_r == SYNC_HI) ? PH_GOT1 : PH_HUNT;
    endcase
  end

  // result
  always_comb begin
    has_res = 1'b0;
    res     = '0;
    unique case (phase_r)
      PH_LEN: begin
        if (!hex_ok) begin
          has_res        = 1'b1;
          res.event_res  = EV_BADLEN;
          res.length     = length_accum_r;
          res.last       = 1'b1;
        end else if (len_final) begin
          has_res        = 1'b1;
          res.length     = len_v;
          if (len_v > max_length_r) begin
            res.event_res = EV_OVER;
            res.last      = 1'b1;
          end else begin
            res.event_res = EV_HEADER;
          end
        end
      end
      PH_DHI, PH_CHI, PH_DLO, PH_CLO: begin
        res.length     = frame_length_r;
        res.byte_index = bytes_done_r;
        if (!hex_ok) begin
          has_res          = 1'b1;
          res.event_res    = EV_BADDATA;
          res.computed_xor = running_xor_r;
          res.last         = 1'b1;
        end else if (phase_r == PH_DLO) begin
          has_res          = 1'b1;
          res.event_res    = EV_DATA;
          res.data_byte    = byte_v;
          res.computed_xor = xor_v;
        end else if (phase_r == PH_CLO) begin
          has_res          = 1'b1;
          res.event_res    = EV_END;
          res.computed_xor = running_xor_r;
          res.received_xor = byte_v;
          res.sum_match    = (byte_v == running_xor_r);
          res.last         = 1'b1;
        end
      end
      default: has_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r   <= MAX_LENGTH_RST;
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      phase_r        <= PH_HUNT;
      digit_count_r  <= '0;
      length_accum_r <= '0;
      frame_length_r <= '0;
      bytes_done_r   <= '0;
      high_nibble_r  <= '0;
      running_xor_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_length_r <= cfg_data;
      end
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        phase_r        <= phase_nxt;
        digit_count_r  <= digit_count_nxt;
        length_accum_r <= length_accum_nxt;
        frame_length_r <= frame_length_nxt;
        bytes_done_r   <= bytes_done_nxt;
        high_nibble_r  <= high_nibble_nxt;
        running_xor_r  <= running_xor_nxt;
      end
      if (adv && has_res) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sym_r <= in_tdata[SYM_W-1:0];
    end
    if (adv && has_res) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.event_res;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {7'd0, out_r.sum_match, out_r.received_xor, out_r.computed_xor,
                       out_r.byte_index, out_r.data_byte, out_r.length};

  `SSFR_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_vld_r, "result valid after reset")
  `SSFR_ASSERT(a_hold_pending, in_vld_r && !adv |=> in_vld_r && $stable(sym_r),
    "pending symbol lost")
  `SSFR_ASSERT(a_last_matches_event,
    out_vld_r |-> (out_r.last == (out_r.event_res != EV_HEADER && out_r.event_res != EV_DATA)),
    "last flag disagrees with event")
  `SSFR_ASSERT(a_ok_only_at_end, out_vld_r && out_r.sum_match |-> out_r.event_res == EV_END,
    "checksum flag outside frame end")

endmodule
